// ===== design/diffusion_stencil_3d_assembler_assert.svh =====
// ----------------------------------------------------------------------------
// Stencil assembler assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIFFUSION_STENCIL_3D_ASSEMBLER_ASSERT_SVH
`define DIFFUSION_STENCIL_3D_ASSEMBLER_ASSERT_SVH

// Same-cycle implication.
`define DSA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stencil assembler assertion failed");

// Next-cycle implication.
`define DSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stencil assembler assertion failed");

`endif

// ===== design/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Stencil assembler package
// Shared widths, register codes and fixed-point helper functions.
// ----------------------------------------------------------------------------
package dsa_pkg;

	localparam int LOG_W      = 4;
	localparam int COEF_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int VAL_W      = 48;
	localparam int SUM_W      = 56;
	localparam int WIDE_W     = 64;
	localparam int KW         = COEF_W + 1;
	localparam int N_ENTRY    = 7;
	localparam int ENT_IDX_W  = 3;

	localparam int MAX_LOG_SIZE_D       = 10;
	localparam int PHASE_BITS_D         = 11;
	localparam int TRIG_FRACTION_BITS_D = 15;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOG_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_OFF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_AMP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REAC_OFF = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REAC_AMP = 3'd6;

	// entry order within one point
	localparam logic [ENT_IDX_W-1:0] ENT_CENTRE = 3'd0;
	localparam logic [ENT_IDX_W-1:0] ENT_DOWN   = 3'd6;

	localparam logic signed [WIDE_W-1:0] ValMax = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
	localparam logic signed [WIDE_W-1:0] ValMin = -(64'sd1 <<< (VAL_W - 1));

	localparam longint unsigned HalfPiQ30 = 64'd1686629713;
	localparam longint unsigned TermDiv [12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
	} lane_en_t;

	// quarter-wave sine entry, evaluated at elaboration only
	function automatic int sine_entry(input int t, input int pb, input int tf);
		longint unsigned a;
		longint unsigned a2;
		longint unsigned term;
		longint          sum;
		int              sh;
		a    = (HalfPiQ30 * longint'(t)) >> (pb - 2);
		a2   = (a * a) >> 30;
		term = a;
		sum  = longint'(a);
		sh   = 30 - tf;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * a2) >> 30) / TermDiv[n-1];
			if (n % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		sum = (sum + (64'sd1 <<< (sh - 1))) >>> sh;
		if (sum > (64'sd1 <<< tf))
			sum = 64'sd1 <<< tf;
		return int'(sum);
	endfunction

	// phase of half-step position m / (2 * 2^l)
	function automatic int unsigned phase_of(input int unsigned m, input int unsigned l,
		input int unsigned pb);
		int unsigned v;
		v = m & ((32'd2 << l) - 32'd1);
		if (pb >= l + 32'd1)
			v = v << (pb - l - 32'd1);
		else
			v = v >> (l + 32'd1 - pb);
		return v & ((32'd1 << pb) - 32'd1);
	endfunction

	// shift right, round to nearest, ties away from zero
	function automatic logic signed [WIDE_W-1:0] round_away(input logic signed [WIDE_W-1:0] v,
		input logic [5:0] sh);
		logic [WIDE_W-1:0] m;
		m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		if (sh == 6'd0)
			return v;
		m = (m + (64'd1 << (sh - 6'd1))) >> sh;
		return v[WIDE_W-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [WIDE_W-1:0] scale_pow2(input logic signed [WIDE_W-1:0] v,
		input logic signed [6:0] e);
		logic signed [6:0] ne;
		ne = -e;
		if (!e[6])
			return v <<< e[5:0];
		return round_away(v, ne[5:0]);
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
		if (v > ValMax)
			return VAL_W'(ValMax);
		if (v < ValMin)
			return VAL_W'(ValMin);
		return VAL_W'(v);
	endfunction

endpackage

// ===== design/dsa_coef_lane.sv =====
// ----------------------------------------------------------------------------
// Coefficient lane
// Triple sine product and affine scaling over four pipeline stages.
// ----------------------------------------------------------------------------
module dsa_coef_lane import dsa_pkg::*; #(
	parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_D,
	localparam int SW = TRIG_FRACTION_BITS + 2
) (
	input  logic                     clk,
	input  lane_en_t                 en,
	input  logic signed [SW-1:0]     sine_a,
	input  logic signed [SW-1:0]     sine_b,
	input  logic signed [SW-1:0]     sine_c,
	input  logic signed [COEF_W-1:0] offset,
	input  logic signed [COEF_W-1:0] amplitude,
	output logic signed [KW-1:0]     coef
);

	localparam logic [5:0] ShF = 6'(TRIG_FRACTION_BITS);

	logic signed [2*SW-1:0]     prod_ab_s3;
	logic signed [SW-1:0]       sine_c_s3;
	logic signed [2*SW-1:0]     prod_abc_s4;
	logic signed [COEF_W+SW-1:0] prod_amp_s5;
	logic signed [KW-1:0]       coef_s6;
	logic signed [SW-1:0]       s12;
	logic signed [SW-1:0]       s123;

	always_comb begin
		s12  = SW'(round_away(WIDE_W'(prod_ab_s3), ShF));
		s123 = SW'(round_away(WIDE_W'(prod_abc_s4), ShF));
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			prod_ab_s3 <= sine_a * sine_b;
			sine_c_s3  <= sine_c;
		end
		if (en.en_s4)
			prod_abc_s4 <= s12 * sine_c_s3;
		if (en.en_s5)
			prod_amp_s5 <= amplitude * s123;
		if (en.en_s6)
			coef_s6 <= KW'(WIDE_W'(offset) + round_away(WIDE_W'(prod_amp_s5), ShF));
	end

	assign coef = coef_s6;

endmodule

// ===== design/diffusion_stencil_3d_assembler.sv =====
// ----------------------------------------------------------------------------
// Seven-point periodic diffusion stencil assembler
// Turns one lattice point into its seven sparse-matrix entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point per beat:
//   x_index, y_index, z_index, each wrapped to the grid size.
//   Output channel (out_valid / out_stall) carries one matrix entry per beat,
//   seven per point in the order centre, south, north, west, east, up, down;
//   last_entry marks the down entry.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   write only while no point is in flight.
//   The centre entry of a point goes from its input beat through pipeline
//   stages 1 to 8 and the serialiser register. Throughput: one entry per
//   cycle while out_stall is low, set by the single output channel; the
//   8-stage pipeline keeps taking points while the entry serialiser is busy.
//   Reset clears every valid bit and restores the registers to sizes 16x16x16,
//   offsets 1.0 and amplitudes 0. There is no clearing pass.
//   When out_stall is high the current entry holds; the pipeline fills behind
//   it and in_stall rises once stage 1 cannot advance.
// ----------------------------------------------------------------------------
`include "diffusion_stencil_3d_assembler_assert.svh"

module diffusion_stencil_3d_assembler import dsa_pkg::*; #(
	parameter int MAX_LOG_SIZE       = MAX_LOG_SIZE_D,
	parameter int PHASE_BITS         = PHASE_BITS_D,
	parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_D,
	localparam int RW = 3 * MAX_LOG_SIZE
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MAX_LOG_SIZE-1:0] x_index,
	input  logic [MAX_LOG_SIZE-1:0] y_index,
	input  logic [MAX_LOG_SIZE-1:0] z_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [RW-1:0]           row_index,
	output logic [RW-1:0]           column_index,
	output logic signed [VAL_W-1:0] entry_value,
	output logic                    last_entry
);

	localparam int QuarterLen = 1 << (PHASE_BITS - 2);
	localparam int IdxW       = PHASE_BITS - 1;
	localparam int TabW       = TRIG_FRACTION_BITS + 1;
	localparam int SW         = TRIG_FRACTION_BITS + 2;
	localparam int ML         = MAX_LOG_SIZE;

	// phase kinds per axis: point, plus half step, minus half step, cosine
	localparam int PH_C   = 0;
	localparam int PH_P   = 1;
	localparam int PH_M   = 2;
	localparam int PH_COS = 3;

	// sine sources of each lane, in entry order
	localparam int LaneKind [N_ENTRY][3] = '{
		'{PH_COS, PH_COS, PH_COS},
		'{PH_C, PH_M, PH_C},
		'{PH_C, PH_P, PH_C},
		'{PH_M, PH_C, PH_C},
		'{PH_P, PH_C, PH_C},
		'{PH_C, PH_C, PH_P},
		'{PH_C, PH_C, PH_M}
	};

	typedef struct packed {
		logic [RW-1:0]              row;
		logic [N_ENTRY-1:0][RW-1:0] col;
	} addr_t;

	// ---------------------------------------------------------------- config
	logic [LOG_W-1:0]         log_x_q, log_y_q, log_z_q;
	logic signed [COEF_W-1:0] diff_off_q, diff_amp_q, reac_off_q, reac_amp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_x_q    <= LOG_W'(4);
			log_y_q    <= LOG_W'(4);
			log_z_q    <= LOG_W'(4);
			diff_off_q <= 32'sh1000_0000;
			diff_amp_q <= '0;
			reac_off_q <= 32'sh1000_0000;
			reac_amp_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LOG_X:    log_x_q    <= cfg_data[LOG_W-1:0];
				REG_LOG_Y:    log_y_q    <= cfg_data[LOG_W-1:0];
				REG_LOG_Z:    log_z_q    <= cfg_data[LOG_W-1:0];
				REG_DIFF_OFF: diff_off_q <= $signed(cfg_data);
				REG_DIFF_AMP: diff_amp_q <= $signed(cfg_data);
				REG_REAC_OFF: reac_off_q <= $signed(cfg_data);
				REG_REAC_AMP: reac_amp_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// clamp sizes to [1, ML]; user, not block, keeps registers quiet while busy
	logic [LOG_W-1:0]  lg [3];
	logic [ML-1:0]     mask [3];
	logic signed [6:0] exp_x, exp_y, exp_z, exp_b;

	always_comb begin
		lg[0] = log_x_q;
		lg[1] = log_y_q;
		lg[2] = log_z_q;
		for (int a = 0; a < 3; a++) begin
			if (lg[a] == '0)
				lg[a] = LOG_W'(1);
			else if (lg[a] > LOG_W'(ML))
				lg[a] = LOG_W'(ML);
			mask[a] = ~({ML{1'b1}} << lg[a]);
		end
		exp_x = 7'sd4 + $signed({3'b0, lg[0]}) - $signed({3'b0, lg[1]}) - $signed({3'b0, lg[2]});
		exp_y = 7'sd4 + $signed({3'b0, lg[1]}) - $signed({3'b0, lg[0]}) - $signed({3'b0, lg[2]});
		exp_z = 7'sd4 + $signed({3'b0, lg[2]}) - $signed({3'b0, lg[0]}) - $signed({3'b0, lg[1]});
		exp_b = 7'sd4 - $signed({3'b0, lg[0]}) - $signed({3'b0, lg[1]}) - $signed({3'b0, lg[2]});
	end

	// --------------------------------------------------------- pipe control
	// A stage takes a new beat when it is empty or its holder moves on.
	logic [8:1] pipe_vld_q;
	logic [9:1] rdy;
	logic       ser_load;
	lane_en_t   lane_en;

	always_comb begin
		rdy[9] = ser_load;
		for (int s = 8; s >= 1; s--)
			rdy[s] = !pipe_vld_q[s] || rdy[s+1];
	end

	assign in_stall = !rdy[1];
	assign lane_en  = '{en_s3: rdy[3], en_s4: rdy[4], en_s5: rdy[5], en_s6: rdy[6]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
		end else begin
			if (rdy[1])
				pipe_vld_q[1] <= in_valid;
			for (int s = 2; s <= 8; s++)
				if (rdy[s])
					pipe_vld_q[s] <= pipe_vld_q[s-1];
		end
	end

	// -------------------------------------------- stage 1: wrap and phases
	logic [ML-1:0]         idx_d [3];
	logic [PHASE_BITS-1:0] phase_d [3][4];
	logic [ML-1:0]         idx_s1 [3];
	logic [PHASE_BITS-1:0] phase_s1 [3][4];

	always_comb begin
		idx_d[0] = x_index & mask[0];
		idx_d[1] = y_index & mask[1];
		idx_d[2] = z_index & mask[2];
		for (int a = 0; a < 3; a++) begin
			phase_d[a][PH_C]   = PHASE_BITS'(phase_of(32'({idx_d[a], 1'b0}), 32'(lg[a]),
				32'(PHASE_BITS)));
			phase_d[a][PH_P]   = PHASE_BITS'(phase_of(32'({idx_d[a], 1'b1}), 32'(lg[a]),
				32'(PHASE_BITS)));
			phase_d[a][PH_M]   = PHASE_BITS'(phase_of(32'({idx_d[a], 1'b0})
				+ (32'd2 << lg[a]) - 32'd1, 32'(lg[a]), 32'(PHASE_BITS)));
			phase_d[a][PH_COS] = phase_d[a][PH_C] + PHASE_BITS'(QuarterLen);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			idx_s1   <= idx_d;
			phase_s1 <= phase_d;
		end
	end

	// ------------------------------------ stage 2: sine lookup, addresses
	logic [TabW-1:0] sine_tab [QuarterLen+1];

	for (genvar t = 0; t <= QuarterLen; t++) begin : g_tab
		assign sine_tab[t] = TabW'(sine_entry(t, PHASE_BITS, TRIG_FRACTION_BITS));
	end

	logic signed [SW-1:0] sine_d [3][4];
	logic signed [SW-1:0] sine_s2 [3][4];
	logic [1:0]           quad;
	logic [IdxW-1:0]      rem;
	logic [IdxW-1:0]      tab_idx;
	logic signed [SW-1:0] mag;

	always_comb begin
		quad    = '0;
		rem     = '0;
		tab_idx = '0;
		mag     = '0;
		for (int a = 0; a < 3; a++) begin
			for (int p = 0; p < 4; p++) begin
				quad    = phase_s1[a][p][PHASE_BITS-1 -: 2];
				rem     = IdxW'(phase_s1[a][p]) & IdxW'(QuarterLen - 1);
				tab_idx = quad[0] ? IdxW'(QuarterLen) - rem : rem;
				mag     = $signed(SW'(sine_tab[tab_idx]));
				sine_d[a][p] = quad[1] ? -mag : mag;
			end
		end
	end

	addr_t         addr_d;
	logic [RW-1:0] base_j, base_k, ci, cj, ck;
	logic [RW-1:0] xm, xp, ym, yp, zm, zp;
	logic [LOG_W:0] sh_xy;

	always_comb begin
		// x and y sizes together can reach 20, so widen before adding
		sh_xy = {1'b0, lg[0]} + {1'b0, lg[1]};
		ci = RW'(idx_s1[0]);
		cj = RW'(idx_s1[1]);
		ck = RW'(idx_s1[2]);
		xm = RW'((idx_s1[0] - ML'(1)) & mask[0]);
		xp = RW'((idx_s1[0] + ML'(1)) & mask[0]);
		ym = RW'((idx_s1[1] - ML'(1)) & mask[1]);
		yp = RW'((idx_s1[1] + ML'(1)) & mask[1]);
		zm = RW'((idx_s1[2] - ML'(1)) & mask[2]);
		zp = RW'((idx_s1[2] + ML'(1)) & mask[2]);
		base_k = ck << sh_xy;
		base_j = cj << lg[0];
		addr_d.row    = base_k + base_j + ci;
		addr_d.col[0] = addr_d.row;
		addr_d.col[1] = base_k + (ym << lg[0]) + ci;
		addr_d.col[2] = base_k + (yp << lg[0]) + ci;
		addr_d.col[3] = base_k + base_j + xm;
		addr_d.col[4] = base_k + base_j + xp;
		addr_d.col[5] = (zp << sh_xy) + base_j + ci;
		addr_d.col[6] = (zm << sh_xy) + base_j + ci;
	end

	addr_t addr_s2, addr_s3, addr_s4, addr_s5, addr_s6, addr_s7, addr_s8;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			sine_s2 <= sine_d;
			addr_s2 <= addr_d;
		end
		if (rdy[3])
			addr_s3 <= addr_s2;
		if (rdy[4])
			addr_s4 <= addr_s3;
		if (rdy[5])
			addr_s5 <= addr_s4;
		if (rdy[6])
			addr_s6 <= addr_s5;
	end

	// ------------------------------ stages 3 to 6: one lane per coefficient
	logic signed [KW-1:0] coef_s6 [N_ENTRY];

	for (genvar l = 0; l < N_ENTRY; l++) begin : g_lane
		dsa_coef_lane #(
			.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
		) u_lane (
			.clk      (clk),
			.en       (lane_en),
			.sine_a   (sine_s2[0][LaneKind[l][0]]),
			.sine_b   (sine_s2[1][LaneKind[l][1]]),
			.sine_c   (sine_s2[2][LaneKind[l][2]]),
			.offset   ((l == 0) ? reac_off_q : diff_off_q),
			.amplitude((l == 0) ? reac_amp_q : diff_amp_q),
			.coef     (coef_s6[l])
		);
	end

	// -------------------------------------------- stage 7: power-of-two scaling
	logic signed [6:0]       ent_exp [N_ENTRY];
	logic signed [VAL_W-1:0] nval_s7 [N_ENTRY-1];
	logic signed [SUM_W-1:0] term_s7 [4];

	always_comb begin
		ent_exp[0] = exp_b;
		ent_exp[1] = exp_y;
		ent_exp[2] = exp_y;
		ent_exp[3] = exp_x;
		ent_exp[4] = exp_x;
		ent_exp[5] = exp_z;
		ent_exp[6] = exp_z;
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			addr_s7 <= addr_s6;
			for (int e = 1; e < N_ENTRY; e++)
				nval_s7[e-1] <= sat_val(-scale_pow2(WIDE_W'(coef_s6[e]), ent_exp[e]));
			term_s7[0] <= SUM_W'(scale_pow2(WIDE_W'(coef_s6[0]), exp_b));
			term_s7[1] <= SUM_W'(scale_pow2(WIDE_W'(coef_s6[3]) + WIDE_W'(coef_s6[4]), exp_x));
			term_s7[2] <= SUM_W'(scale_pow2(WIDE_W'(coef_s6[1]) + WIDE_W'(coef_s6[2]), exp_y));
			term_s7[3] <= SUM_W'(scale_pow2(WIDE_W'(coef_s6[5]) + WIDE_W'(coef_s6[6]), exp_z));
		end
	end

	// ------------------------------------------------- stage 8: centre sum
	logic signed [VAL_W-1:0] val_s8 [N_ENTRY];

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			addr_s8   <= addr_s7;
			val_s8[0] <= sat_val(WIDE_W'(term_s7[0]) + WIDE_W'(term_s7[1])
				+ WIDE_W'(term_s7[2]) + WIDE_W'(term_s7[3]));
			for (int e = 1; e < N_ENTRY; e++)
				val_s8[e] <= nval_s7[e-1];
		end
	end

	// ------------------------------------------------------- entry serialiser
	// Hold one point; step through its seven entries, one beat each.
	logic                    out_vld_q;
	logic [ENT_IDX_W-1:0]    cnt_q;
	addr_t                   ser_addr_q;
	logic signed [VAL_W-1:0] ser_val_q [N_ENTRY];

	assign ser_load = !out_vld_q || (!out_stall && cnt_q == ENT_DOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			cnt_q     <= ENT_CENTRE;
		end else if (ser_load) begin
			out_vld_q <= pipe_vld_q[8];
			cnt_q     <= ENT_CENTRE;
		end else if (!out_stall) begin
			cnt_q <= cnt_q + ENT_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load && pipe_vld_q[8]) begin
			ser_addr_q <= addr_s8;
			ser_val_q  <= val_s8;
		end
	end

	assign out_valid    = out_vld_q;
	assign row_index    = ser_addr_q.row;
	assign column_index = ser_addr_q.col[cnt_q];
	assign entry_value  = ser_val_q[cnt_q];
	assign last_entry   = (cnt_q == ENT_DOWN);

	// ------------------------------------------------------------ assertions
	`DSA_ASSERT_NEXT(a_in_captured, in_valid && !in_stall, pipe_vld_q[1])
	`DSA_ASSERT_NEXT(a_entry_step, out_valid && !out_stall && cnt_q != ENT_DOWN,
		out_valid && cnt_q == $past(cnt_q) + ENT_IDX_W'(1))
	`DSA_ASSERT_NEXT(a_tail_held, pipe_vld_q[8] && !ser_load,
		pipe_vld_q[8] && $stable(val_s8[0]))
	`DSA_ASSERT_IMPL(a_count_range, out_valid, cnt_q <= ENT_DOWN)

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Stencil assembler testbench
// Feeds lattice points through the seven-point stencil assembler under
// random idling on both channels, across several grid and coefficient
// settings, and checks every matrix entry against an in-bench prediction
// built from a fixed-point sine table of its own.
// ----------------------------------------------------------------------------
module tb import dsa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W  = 10;
	localparam int ROW_W  = 30;
	localparam int PB     = 11;
	localparam int TF     = 15;
	localparam int QLEN   = 1 << (PB - 2);
	localparam int MAX_L  = 10;
	// an index past the register list; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [ROW_W-1:0]       row;
		logic [ROW_W-1:0]       col;
		logic signed [VAL_W-1:0] val;
		logic                   last;
	} entry_t;

	// Stencil predictor and store of pending matrix entries.
	class stencil_board;
		longint sine_q[QLEN + 1];
		int unsigned log_x, log_y, log_z;
		longint d_off, d_amp, r_off, r_amp;
		entry_t pending[$];
		int errors;
		int points;
		int entries;

		function new();
			longint unsigned a, a2, term;
			longint sum;
			for (int t = 0; t <= QLEN; t++) begin
				a    = (64'd1686629713 * longint'(t)) >> (PB - 2);
				a2   = (a * a) >> 30;
				term = a;
				sum  = longint'(a);
				for (int n = 1; n <= 12; n++) begin
					term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1)
						sum -= longint'(term);
					else
						sum += longint'(term);
				end
				if (sum < 0)
					sum = 0;
				sum = (sum + (64'sd1 <<< (30 - TF - 1))) >>> (30 - TF);
				if (sum > (64'sd1 <<< TF))
					sum = 64'sd1 <<< TF;
				sine_q[t] = sum;
			end
			set_reg(REG_LOG_X, 4);
			set_reg(REG_LOG_Y, 4);
			set_reg(REG_LOG_Z, 4);
			set_reg(REG_DIFF_OFF, 32'h1000_0000);
			set_reg(REG_DIFF_AMP, 0);
			set_reg(REG_REAC_OFF, 32'h1000_0000);
			set_reg(REG_REAC_AMP, 0);
			errors = 0;
			points = 0;
			entries = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_LOG_X: log_x = data[3:0];
				REG_LOG_Y: log_y = data[3:0];
				REG_LOG_Z: log_z = data[3:0];
				REG_DIFF_OFF: d_off = longint'($signed(data));
				REG_DIFF_AMP: d_amp = longint'($signed(data));
				REG_REAC_OFF: r_off = longint'($signed(data));
				REG_REAC_AMP: r_amp = longint'($signed(data));
				default: ;
			endcase
		endfunction

		function longint round_away(longint v, int sh);
			longint unsigned m;
			if (sh == 0)
				return v;
			m = (v < 0) ? longint'(-v) : longint'(v);
			m = (m + (64'd1 << (sh - 1))) >> sh;
			return (v < 0) ? -longint'(m) : longint'(m);
		endfunction

		function longint pow2(longint v, int e);
			if (e >= 0)
				return v <<< e;
			return round_away(v, -e);
		endfunction

		function longint sat(longint v);
			if (v > 64'sd140737488355327)
				return 64'sd140737488355327;
			if (v < -64'sd140737488355328)
				return -64'sd140737488355328;
			return v;
		endfunction

		function longint sine(int unsigned p);
			int unsigned q, r;
			p &= (1 << PB) - 1;
			q = p >> (PB - 2);
			r = p & (QLEN - 1);
			case (q)
				0: return sine_q[r];
				1: return sine_q[QLEN - r];
				2: return -sine_q[r];
				default: return -sine_q[QLEN - r];
			endcase
		endfunction

		function int unsigned phase(int unsigned m, int unsigned l);
			m &= (2 << l) - 1;
			if (PB >= l + 1)
				m = m << (PB - l - 1);
			else
				m = m >> (l + 1 - PB);
			return m & ((1 << PB) - 1);
		endfunction

		function longint coef(longint off, longint amp, int unsigned p1, int unsigned p2,
			int unsigned p3, int unsigned sh);
			longint s12, s123;
			s12  = round_away(sine(p1 + sh) * sine(p2 + sh), TF);
			s123 = round_away(s12 * sine(p3 + sh), TF);
			return off + round_away(amp * s123, TF);
		endfunction

		function int unsigned clamp_l(int unsigned v);
			if (v < 1)
				return 1;
			if (v > MAX_L)
				return MAX_L;
			return v;
		endfunction

		function void push(int unsigned row, int unsigned col, longint v, logic last);
			entry_t e;
			e.row  = row[ROW_W-1:0];
			e.col  = col[ROW_W-1:0];
			e.val  = VAL_W'(sat(v));
			e.last = last;
			pending = {pending, e};
		endfunction

		// Work out the seven entries of one accepted point.
		function void note_point(int unsigned xi, int unsigned yi, int unsigned zi);
			int unsigned lx, ly, lz, nx, ny, nz, i, j, k, row, bk, bj;
			int unsigned px, pxe, pxw, py, pyn, pys, pz, pzu, pzd;
			longint kn, ks, ke, kw, ku, kd, bc, ctr;
			int ex, ey, ez, eb;
			lx = clamp_l(log_x);
			ly = clamp_l(log_y);
			lz = clamp_l(log_z);
			nx = 1 << lx;
			ny = 1 << ly;
			nz = 1 << lz;
			i = xi & (nx - 1);
			j = yi & (ny - 1);
			k = zi & (nz - 1);
			px  = phase(2 * i, lx);
			pxe = phase(2 * i + 1, lx);
			pxw = phase(2 * i + 2 * nx - 1, lx);
			py  = phase(2 * j, ly);
			pyn = phase(2 * j + 1, ly);
			pys = phase(2 * j + 2 * ny - 1, ly);
			pz  = phase(2 * k, lz);
			pzu = phase(2 * k + 1, lz);
			pzd = phase(2 * k + 2 * nz - 1, lz);
			kn = coef(d_off, d_amp, px, pyn, pz, 0);
			ks = coef(d_off, d_amp, px, pys, pz, 0);
			ke = coef(d_off, d_amp, pxe, py, pz, 0);
			kw = coef(d_off, d_amp, pxw, py, pz, 0);
			ku = coef(d_off, d_amp, px, py, pzu, 0);
			kd = coef(d_off, d_amp, px, py, pzd, 0);
			bc = coef(r_off, r_amp, px, py, pz, QLEN);
			ex = int'(lx) - int'(ly) - int'(lz) + 4;
			ey = int'(ly) - int'(lx) - int'(lz) + 4;
			ez = int'(lz) - int'(lx) - int'(ly) + 4;
			eb = 4 - int'(lx + ly + lz);
			ctr = pow2(bc, eb) + pow2(ke + kw, ex) + pow2(kn + ks, ey) + pow2(ku + kd, ez);
			bk  = k << (lx + ly);
			bj  = j << lx;
			row = bk + bj + i;
			push(row, row, ctr, 1'b0);
			push(row, bk + (((j + ny - 1) & (ny - 1)) << lx) + i, -pow2(ks, ey), 1'b0);
			push(row, bk + (((j + 1) & (ny - 1)) << lx) + i, -pow2(kn, ey), 1'b0);
			push(row, bk + bj + ((i + nx - 1) & (nx - 1)), -pow2(kw, ex), 1'b0);
			push(row, bk + bj + ((i + 1) & (nx - 1)), -pow2(ke, ex), 1'b0);
			push(row, (((k + 1) & (nz - 1)) << (lx + ly)) + bj + i, -pow2(ku, ez), 1'b0);
			push(row, (((k + nz - 1) & (nz - 1)) << (lx + ly)) + bj + i, -pow2(kd, ez), 1'b1);
			points++;
		endfunction

		function void fail_note(string what, longint exp_v, longint act_v);
			errors++;
			if (errors <= 30)
				$display("%t: %s mismatch: expected %0d, actual %0d", $realtime, what,
					exp_v, act_v);
		endfunction

		// Compare one entry beat with the oldest prediction.
		function void check_entry(entry_t got);
			entry_t e;
			entries++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 30)
					$display("%t: unexpected entry, expected none, actual row %0d col %0d",
						$realtime, got.row, got.col);
				return;
			end
			e = pending.pop_front();
			if (got.row !== e.row)
				fail_note("row_index", e.row, got.row);
			if (got.col !== e.col)
				fail_note("column_index", e.col, got.col);
			if (got.val !== e.val)
				fail_note("entry_value", e.val, got.val);
			if (got.last !== e.last)
				fail_note("last_entry", e.last, got.last);
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [IDX_W-1:0]        x_index;
	logic [IDX_W-1:0]        y_index;
	logic [IDX_W-1:0]        z_index;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [ROW_W-1:0]        row_index;
	logic [ROW_W-1:0]        column_index;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last_entry;

	stencil_board board;
	bit idle_on;
	int stall_left = 0;

	diffusion_stencil_3d_assembler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_index     (x_index),
		.y_index     (y_index),
		.z_index     (z_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_index   (row_index),
		.column_index(column_index),
		.entry_value (entry_value),
		.last_entry  (last_entry)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit: far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver side: random stall bursts, none once idling is switched off.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 17);
			out_stall <= 1'b1;
		end
	end

	// Take each entry beat as it is accepted; values here are the pre-edge ones.
	always @(posedge clk) begin
		entry_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.row  = row_index;
			got.col  = column_index;
			got.val  = entry_value;
			got.last = last_entry;
			board.check_entry(got);
		end
	end

	// Drive one register write up to a clock edge; the caller drops cfg_write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		board.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic write_all(input logic [3:0] lx, input logic [3:0] ly, input logic [3:0] lz,
		input logic [31:0] doff, input logic [31:0] damp, input logic [31:0] roff,
		input logic [31:0] ramp);
		write_reg(REG_LOG_X, {28'd0, lx});
		write_reg(REG_LOG_Y, {28'd0, ly});
		write_reg(REG_LOG_Z, {28'd0, lz});
		write_reg(REG_DIFF_OFF, doff);
		write_reg(REG_DIFF_AMP, damp);
		write_reg(REG_REAC_OFF, roff);
		write_reg(REG_REAC_AMP, ramp);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one point, with an optional gap first; note it when the beat lands.
	task automatic send_point(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
		input logic [IDX_W-1:0] z);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_index  <= x;
		y_index  <= y;
		z_index  <= z;
		do
			@(posedge clk);
		while (in_stall);
		board.note_point(x, y, z);
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_point(IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
				IDX_W'($urandom_range(0, 1023)));
	endtask

	// Drop valid and let the block drain before touching the registers.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		board = new();
		idle_on = 1'b0;
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_LOG_X;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		x_index   <= '0;
		y_index   <= '0;
		z_index   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings first: corners, all-ones indexes that wrap, west wrap at 0.
		send_point(10'd0, 10'd0, 10'd0);
		send_point(10'd1023, 10'd1023, 10'd1023);
		send_point(10'd15, 10'd0, 10'd15);
		send_point(10'd16, 10'd17, 10'd31);
		send_point(10'h2AA, 10'h155, 10'h3C3);
		drain();

		// Sine terms live; a write past the register list must change nothing.
		write_all(4'd3, 4'd5, 4'd2, 32'h1000_0000, 32'h0800_0000, 32'h0400_0000,
			32'hF800_0000);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		cfg_write <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < 8; n++)
			send_point(IDX_W'(n), IDX_W'(n * 5), IDX_W'(n * 3));
		drain();

		// Log sizes out of range get clamped; extreme coefficients.
		write_all(4'd0, 4'd15, 4'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF);
		idle_on = 1'b1;
		send_point(10'd0, 10'd1023, 10'd1);
		send_point(10'd1, 10'd0, 10'd0);
		send_point(10'd1023, 10'd512, 10'd3);
		send_random(30);
		drain();

		// Flattest grid along y and z, widest along x: largest positive scaling.
		write_all(4'd10, 4'd1, 4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000);
		send_point(10'd0, 10'd0, 10'd0);
		send_point(10'd1023, 10'd1, 10'd1);
		send_random(35);
		drain();

		// Largest grid on all axes: deep negative scaling and rounding.
		write_all(4'd10, 4'd10, 4'd10, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF);
		send_random(35);
		drain();

		// Random settings, some with sizes outside the legal range.
		repeat (3) begin
			write_all(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), $urandom(), $urandom(), $urandom(), $urandom());
			send_random(35);
			drain();
		end

		// Final stretch at full rate on both sides.
		write_all(4'd2, 4'd7, 4'd9, $urandom(), $urandom(), $urandom(), $urandom());
		idle_on = 1'b0;
		send_random(30);
		drain();
		repeat (20) @(posedge clk);

		$display("Covered %0d points and %0d entry beats over nine register settings,",
			board.points, board.entries);
		$display("including clamped sizes, index wrap and coefficient extremes.");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d failures, %0d entries never arrived", board.errors,
				board.pending.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
